>>> design/fcc16_pkg.sv
// Package for the CRC-16/DNP frame checker: verdict codes, frame constants
// and the one-byte CRC update. No dependencies.
package fcc16_pkg;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SYNC  = 3'd1,
        ST_COMPL = 3'd2,
        ST_CRC   = 3'd3,
        ST_ADDR  = 3'd4,
        ST_LONG  = 3'd5
    } status_t;

    // Frame constants
    localparam logic [7:0]  SYNC0     = 8'hAA;
    localparam logic [7:0]  SYNC1     = 8'hBB;
    localparam logic [7:0]  SYNC2     = 8'hCC;
    localparam logic [7:0]  BCAST_A   = 8'hF5;
    localparam logic [7:0]  BCAST_B   = 8'hF8;
    localparam logic [15:0] POLY_REFL = 16'hA6BC;
    localparam logic [15:0] ALL_ONES  = 16'hFFFF;
    localparam logic [8:0]  LEN_SAT   = 9'd511;

    // Frame byte offsets
    localparam logic [3:0] POS_SYNC0 = 4'd0;
    localparam logic [3:0] POS_SYNC1 = 4'd1;
    localparam logic [3:0] POS_SYNC2 = 4'd2;
    localparam logic [3:0] POS_LEN_H = 4'd3;
    localparam logic [3:0] POS_LEN_L = 4'd4;
    localparam logic [3:0] POS_CMP_H = 4'd5;
    localparam logic [3:0] POS_CMP_L = 4'd6;
    localparam logic [3:0] POS_DEST  = 4'd7;
    localparam logic [3:0] POS_SRC   = 4'd8;
    localparam logic [3:0] POS_CMD   = 4'd9;

    // Reflected CRC-16/DNP update over one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> design/fcc16_if.sv
// Valid/ready channels of the frame checker: received bytes in, verdicts out.
// Depends on fcc16_pkg for the verdict code type.
interface fcc16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface fcc16_out_if;
    logic              valid;
    logic              ready;
    fcc16_pkg::status_t status;
    logic [8:0]        payload_length;
    logic [7:0]        dest_address;
    logic [7:0]        source_address;
    logic [7:0]        command_code;

    modport source (output valid, output status, output payload_length,
                    output dest_address, output source_address,
                    output command_code, input ready);
    modport sink   (input valid, input status, input payload_length,
                    input dest_address, input source_address,
                    input command_code, output ready);
endinterface

>>> design/frame_check_crc16.sv
// Frame checker with CRC-16/DNP: byte-by-byte frame parsing and at most one verdict.
// Depends on fcc16_pkg and the channel interfaces in fcc16_if.sv.
//
// Usage:
//   frame_in carries one received byte per item; frame_start marks byte 0
//   and restarts checking at any point, even mid-frame. Without a frame
//   start after a verdict, bytes are taken and dropped.
//   verdict carries at most one item per frame: status, length field
//   (saturated at 511), destination, source and command bytes. It is given
//   at the first error (sync, length complement, too long, not addressed)
//   or after the second CRC byte (ok or bad CRC).
//   wr_en/wr_data load the station address; write it only while idle.
// Timing:
//   one byte is taken every cycle unless a verdict waits and is not taken;
//   a verdict appears in the output register in the cycle after the byte
//   that decides it. The path per byte: eight-step CRC update, length checks.
// Reset: the checker waits for a frame start, the station address is 0 and
//   the output register is empty.
// Stall: while a verdict waits, a new byte is still taken if the receiver
//   takes the waiting verdict in the same cycle; otherwise frame_in.ready
//   stays low.
module frame_check_crc16 #(
    parameter int unsigned MAX_FRAME = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    fcc16_in_if.sink          frame_in,
    fcc16_out_if.source       verdict,
    input  logic              wr_en,
    input  logic [7:0]        wr_data
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME);
    localparam logic [16:0] MAX_FRAME_W = 17'(MAX_FRAME);

    // Frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       cmp_hi_reg, cmp_hi_next;
    logic [7:0]       dest_reg, dest_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic             done_reg, done_next;
    logic [7:0]       own_addr_reg;

    // Output register
    logic               out_valid_reg;
    fcc16_pkg::status_t status_reg;
    logic [8:0]         plen_reg;
    logic [7:0]         odest_reg;
    logic [7:0]         osrc_reg;
    logic [7:0]         ocmd_reg;

    // Per-item working values
    logic               in_acc;
    logic               give;
    fcc16_pkg::status_t give_status;
    logic [POS_W-1:0]   p;
    logic [16:0]        p_w;
    logic [16:0]        len_w;
    logic [15:0]        cmp_word;
    logic [7:0]         b;
    logic               in_body;
    logic [15:0]        crc_upd;

    assign frame_in.ready = !out_valid_reg || verdict.ready;
    assign in_acc         = frame_in.valid && frame_in.ready;
    assign b              = frame_in.rx_byte;

    // Parse one byte: restart, advance the position, update CRC and fields, decide the verdict
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        len_next    = len_reg;
        cmp_hi_next = cmp_hi_reg;
        dest_next   = dest_reg;
        src_next    = src_reg;
        cmd_next    = cmd_reg;
        crc_hi_next = crc_hi_reg;
        done_next   = done_reg;
        give        = 1'b0;
        give_status = fcc16_pkg::ST_OK;

        if (frame_in.frame_start)
        begin
            pos_next    = '0;
            crc_next    = '0;
            len_next    = '0;
            cmp_hi_next = '0;
            dest_next   = '0;
            src_next    = '0;
            cmd_next    = '0;
            crc_hi_next = '0;
            done_next   = 1'b0;
        end

        p        = pos_next;
        p_w      = 17'(p);
        len_w    = {1'b0, len_next};
        cmp_word = {cmp_hi_next, b};
        in_body  = (p_w < 17'(fcc16_pkg::POS_DEST)) || (p_w <= len_w + 17'd7);
        crc_upd  = fcc16_pkg::crc_feed(crc_next, b);

        if (!done_next)
        begin
            pos_next = p + POS_W'(1);
            priority if (p_w == 17'(fcc16_pkg::POS_SYNC0))
            begin
                give = (b != fcc16_pkg::SYNC0);
                give_status = fcc16_pkg::ST_SYNC;
            end
            else if (p_w == 17'(fcc16_pkg::POS_SYNC1))
            begin
                give = (b != fcc16_pkg::SYNC1);
                give_status = fcc16_pkg::ST_SYNC;
            end
            else if (p_w == 17'(fcc16_pkg::POS_SYNC2))
            begin
                give = (b != fcc16_pkg::SYNC2);
                give_status = fcc16_pkg::ST_SYNC;
            end
            else if (in_body)
            begin
                crc_next = crc_upd;
                if (p_w == 17'(fcc16_pkg::POS_LEN_H))
                    len_next = {b, 8'h00};
                else if (p_w == 17'(fcc16_pkg::POS_LEN_L))
                    len_next = {len_next[15:8], b};
                else if (p_w == 17'(fcc16_pkg::POS_CMP_H))
                    cmp_hi_next = b;
                else if (p_w == 17'(fcc16_pkg::POS_CMP_L))
                begin
                    if ((len_next + cmp_word) != fcc16_pkg::ALL_ONES)
                    begin
                        give = 1'b1;
                        give_status = fcc16_pkg::ST_COMPL;
                    end
                    else if ((len_w + 17'd10) > MAX_FRAME_W)
                    begin
                        give = 1'b1;
                        give_status = fcc16_pkg::ST_LONG;
                    end
                end
                else if (p_w == 17'(fcc16_pkg::POS_DEST))
                begin
                    dest_next = b;
                    if (b != fcc16_pkg::BCAST_A && b != fcc16_pkg::BCAST_B
                        && b != own_addr_reg)
                    begin
                        give = 1'b1;
                        give_status = fcc16_pkg::ST_ADDR;
                    end
                end
                else if (p_w == 17'(fcc16_pkg::POS_SRC))
                    src_next = b;
                else if (p_w == 17'(fcc16_pkg::POS_CMD))
                    cmd_next = b;
            end
            else if (p_w == len_w + 17'd8)
                crc_hi_next = b;
            else
            begin
                give = 1'b1;
                give_status = ({crc_hi_next, b} == ~crc_next) ?
                              fcc16_pkg::ST_OK : fcc16_pkg::ST_CRC;
            end
            if (give)
                done_next = 1'b1;
        end
    end

    // Hold frame state; advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            crc_reg    <= '0;
            len_reg    <= '0;
            cmp_hi_reg <= '0;
            dest_reg   <= '0;
            src_reg    <= '0;
            cmd_reg    <= '0;
            crc_hi_reg <= '0;
            done_reg   <= 1'b1;
        end
        else if (in_acc)
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            len_reg    <= len_next;
            cmp_hi_reg <= cmp_hi_next;
            dest_reg   <= dest_next;
            src_reg    <= src_next;
            cmd_reg    <= cmd_next;
            crc_hi_reg <= crc_hi_next;
            done_reg   <= done_next;
        end
    end

    // Load the station address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_addr_reg <= '0;
        else if (wr_en)
            own_addr_reg <= wr_data;
    end

    // Output register: load a verdict, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc)
            out_valid_reg <= give;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && give)
        begin
            status_reg <= give_status;
            plen_reg   <= (len_next > 16'(fcc16_pkg::LEN_SAT)) ?
                          fcc16_pkg::LEN_SAT : len_next[8:0];
            odest_reg  <= dest_next;
            osrc_reg   <= src_next;
            ocmd_reg   <= cmd_next;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.status         = status_reg;
    assign verdict.payload_length = plen_reg;
    assign verdict.dest_address   = odest_reg;
    assign verdict.source_address = osrc_reg;
    assign verdict.command_code   = ocmd_reg;

    // A new verdict only follows an accepted byte
    a_verdict_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_acc))
        else $error("verdict appeared without an accepted byte");

    // Once a verdict is given the position is frozen until a frame start
    a_idle_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !(in_acc && frame_in.frame_start)) |=> $stable(pos_reg))
        else $error("position moved while idle");

    // A good frame always has a length that fits the frame limit
    a_ok_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == fcc16_pkg::ST_OK)
            |-> (32'(plen_reg) + 32'd10 <= 32'(MAX_FRAME)))
        else $error("good verdict with an oversized length");

endmodule
